[rtl/core/utf8_to_utf16_transcoder_defines.svh]
// Assertion macros for the UTF-8 to UTF-16 transcoder.
// No dependencies; included by the files that carry concurrent checks.
`ifndef UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH
`define UTF8_TO_UTF16_TRANSCODER_DEFINES_SVH

`ifndef SYNTHESIS
// Check that expr holds at every clock edge outside reset.
`define U8U16_ASSERT_ALWAYS(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (expr)) \
		else $error("assertion failed");
// Check that cons holds at the edge after ante.
`define U8U16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define U8U16_ASSERT_ALWAYS(lbl, clk, rst_n, expr)
`define U8U16_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif

`endif

[rtl/core/u8u16_pkg.sv]
// Shared types and constants for the UTF-8 to UTF-16 transcoder.
// No dependencies.
`timescale 1ns / 1ps

package u8u16_pkg;

	localparam logic [15:0] CAP_RESET   = 16'd256;
	localparam int          QUEUE_DEPTH = 4;

	typedef enum logic [1:0] {
		KIND_DATA = 2'd0,
		KIND_ZERO = 2'd1,
		KIND_BAD  = 2'd2,
		KIND_FULL = 2'd3
	} kind_t;

	typedef struct packed {
		logic [15:0] code_unit;
		kind_t       unit_kind;
		logic        last;
	} unit_t;

	typedef struct packed {
		logic [30:0] acc;
		logic [2:0]  pend;
		logic [15:0] space;
		logic        fin;
	} dec_state_t;

endpackage

[rtl/core/u8u16_if.sv]
// Handshake channels of the transcoder: input bytes, output units, config writes.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

interface u8u16_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       start_string;

	modport source (output valid, output in_byte, output start_string, input ready);
	modport sink   (input valid, input in_byte, input start_string, output ready);
endinterface

interface u8u16_out_if;
	logic                 valid;
	logic                 ready;
	logic [15:0]          code_unit;
	u8u16_pkg::kind_t     unit_kind;
	logic                 last;

	modport source (output valid, output code_unit, output unit_kind, output last,
		input ready);
	modport sink   (input valid, input code_unit, input unit_kind, input last,
		output ready);
endinterface

interface u8u16_cfg_if;
	logic        valid;
	logic        ready;
	logic [15:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

[rtl/core/utf8_to_utf16_transcoder.sv]
// Top level of the UTF-8 to UTF-16 transcoder: input register, decode step,
// output unit queue. Depends on u8u16_pkg, u8u16_if, u8u16_step and the defines header.
`timescale 1ns / 1ps
`include "utf8_to_utf16_transcoder_defines.svh"

// Takes one UTF-8 byte per cycle while the queue has room and returns UTF-16
// units. A byte is registered, decoded from that register once the queue has
// room, and its units enter a four-entry output queue. Bytes are taken back to
// back as long as the queue has two free entries; a surrogate pair occupies two
// queue entries, and the output gives one unit per cycle while out_stream.ready
// is held. The capacity register is read only when start_string is set, so a
// write applies from the next string on.

module utf8_to_utf16_transcoder (
	input  logic        clk,
	input  logic        arst_n,
	u8u16_cfg_if.sink   cfg,
	u8u16_in_if.sink    in_stream,
	u8u16_out_if.source out_stream
);
	import u8u16_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);
	localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

	logic [15:0]      cap_q;
	logic             valid_s1;
	logic [7:0]       byte_s1;
	logic             start_s1;
	dec_state_t       state_q;
	dec_state_t       state_nxt;
	logic [1:0]       n_units;
	unit_t            unit0;
	unit_t            unit1;
	unit_t            queue_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] cnt_q;
	logic             fire;
	logic             pop;
	logic [1:0]       push_n;

	// config register
	assign cfg.ready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= CAP_RESET;
		end else if (cfg.valid) begin
			cap_q <= cfg.data;
		end
	end

	// decode a byte only when both of its possible units fit in the queue
	assign fire            = valid_s1 && (cnt_q <= CNT_W'(QUEUE_DEPTH - 2));
	assign in_stream.ready = !valid_s1 || fire;
	assign pop             = out_stream.valid && out_stream.ready;
	assign push_n          = fire ? n_units : 2'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_stream.valid && in_stream.ready) begin
			valid_s1 <= 1'b1;
		end else if (fire) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_stream.valid && in_stream.ready) begin
			byte_s1  <= in_stream.in_byte;
			start_s1 <= in_stream.start_string;
		end
	end

	u8u16_step u_step (
		.cur          (state_q),
		.in_byte      (byte_s1),
		.start_string (start_s1),
		.cap          (cap_q),
		.nxt          (state_nxt),
		.n_units      (n_units),
		.unit0        (unit0),
		.unit1        (unit1)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{acc: '0, pend: '0, space: CAP_RESET, fin: 1'b0};
		end else if (fire) begin
			state_q <= state_nxt;
		end
	end

	// output queue
	always_ff @(posedge clk) begin
		if (push_n != 2'd0) begin
			queue_q[wr_ptr_q] <= unit0;
		end
		if (push_n == 2'd2) begin
			queue_q[wr_ptr_q + PTR_W'(1)] <= unit1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			wr_ptr_q <= wr_ptr_q + PTR_W'(push_n);
			rd_ptr_q <= rd_ptr_q + PTR_W'(pop);
			cnt_q    <= cnt_q + CNT_W'(push_n) - CNT_W'(pop);
		end
	end

	assign out_stream.valid     = (cnt_q != '0);
	assign out_stream.code_unit = queue_q[rd_ptr_q].code_unit;
	assign out_stream.unit_kind = queue_q[rd_ptr_q].unit_kind;
	assign out_stream.last      = queue_q[rd_ptr_q].last;

	`U8U16_ASSERT_ALWAYS(a_queue_bound, clk, arst_n, cnt_q <= CNT_W'(QUEUE_DEPTH))
	`U8U16_ASSERT_ALWAYS(a_quiet_after_end, clk, arst_n,
		!(fire && state_q.fin && !start_s1) || (n_units == 2'd0))
	`U8U16_ASSERT_ALWAYS(a_pair_is_data, clk, arst_n,
		!(fire && n_units == 2'd2) || (!unit0.last && !unit1.last))
	`U8U16_ASSERT_NEXT(a_space_shrinks, clk, arst_n, fire && !start_s1,
		state_q.space <= $past(state_q.space))

endmodule

[rtl/core/u8u16_step.sv]
// Per-byte decode step: next decoder state and up to two UTF-16 units.
// Depends on u8u16_pkg.
`timescale 1ns / 1ps

module u8u16_step (
	input  u8u16_pkg::dec_state_t cur,
	input  logic [7:0]            in_byte,
	input  logic                  start_string,
	input  logic [15:0]           cap,
	output u8u16_pkg::dec_state_t nxt,
	output logic [1:0]            n_units,
	output u8u16_pkg::unit_t      unit0,
	output u8u16_pkg::unit_t      unit1
);
	import u8u16_pkg::*;

	dec_state_t  st;
	logic [30:0] acc_sh;
	logic [30:0] cp;
	logic [30:0] cp_off;
	logic        emit_req;
	logic        term;
	kind_t       term_kind;
	logic        big;

	always_comb begin
		st = cur;
		if (start_string) begin
			st.acc   = '0;
			st.pend  = '0;
			st.space = cap;
			st.fin   = 1'b0;
		end
		acc_sh    = {st.acc[24:0], in_byte[5:0]};
		nxt       = st;
		n_units   = 2'd0;
		unit0     = '{code_unit: 16'd0, unit_kind: KIND_DATA, last: 1'b0};
		unit1     = '{code_unit: 16'd0, unit_kind: KIND_DATA, last: 1'b0};
		emit_req  = 1'b0;
		cp        = '0;
		term      = 1'b0;
		term_kind = KIND_DATA;

		if (!st.fin) begin
			if (st.pend != 3'd0) begin
				if (in_byte[7:6] != 2'b10) begin
					term      = 1'b1;
					term_kind = KIND_BAD;
				end else begin
					nxt.pend = st.pend - 3'd1;
					if (st.pend == 3'd1) begin
						emit_req = 1'b1;
						cp       = acc_sh;
						nxt.acc  = '0;
					end else begin
						nxt.acc = acc_sh;
					end
				end
			end else if (in_byte == 8'd0) begin
				term      = 1'b1;
				term_kind = KIND_ZERO;
			end else if (!in_byte[7]) begin
				emit_req = 1'b1;
				cp       = {23'd0, in_byte};
			end else if (in_byte[7:5] == 3'b110) begin
				nxt.acc  = {26'd0, in_byte[4:0]};
				nxt.pend = 3'd1;
			end else if (in_byte[7:4] == 4'b1110) begin
				nxt.acc  = {27'd0, in_byte[3:0]};
				nxt.pend = 3'd2;
			end else if (in_byte[7:3] == 5'b11110) begin
				nxt.acc  = {28'd0, in_byte[2:0]};
				nxt.pend = 3'd3;
			end else if (in_byte[7:2] == 6'b111110) begin
				nxt.acc  = {29'd0, in_byte[1:0]};
				nxt.pend = 3'd4;
			end else if (in_byte[7:1] == 7'b1111110) begin
				nxt.acc  = {30'd0, in_byte[0]};
				nxt.pend = 3'd5;
			end else begin
				term      = 1'b1;
				term_kind = KIND_BAD;
			end
		end

		big    = (cp[30:16] != 15'd0);
		cp_off = cp - 31'h0001_0000;

		if (emit_req) begin
			if (cp == 31'd0) begin
				term      = 1'b1;
				term_kind = KIND_ZERO;
			end else if (big ? (st.space < 16'd6) : (st.space < 16'd4)) begin
				// unit(s) plus terminator no longer fit
				term      = 1'b1;
				term_kind = KIND_FULL;
			end else if (!big) begin
				nxt.space       = st.space - 16'd2;
				n_units         = 2'd1;
				unit0.code_unit = cp[15:0];
			end else begin
				nxt.space       = st.space - 16'd4;
				n_units         = 2'd2;
				unit0.code_unit = cp_off[25:10] + 16'hD800;
				unit1.code_unit = {6'b110111, cp_off[9:0]};
			end
		end

		if (term) begin
			nxt.fin   = 1'b1;
			nxt.pend  = '0;
			nxt.acc   = '0;
			n_units   = 2'd1;
			unit0     = '{code_unit: 16'd0, unit_kind: term_kind, last: 1'b1};
		end
	end

endmodule
